>>> rtl/core/pr80_pkg.sv
// PRESENT-80 encryption package: stage record type, configuration register
// indexes and the round functions (S-box, permutation, key update).
// No dependencies.
package pr80_pkg;

  localparam int BLK_W       = 64;
  localparam int KEY_W       = 80;
  localparam int KEY_HIGH_W  = 16;
  localparam int RC_W        = 5;
  localparam int ROUNDS_DEF  = 31;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

  // One pipeline slot: the block in flight and the round key that travels with it.
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] state;
    logic [KEY_W-1:0] key;
  } pr80_stage_t;

  // The 4-bit S-box.
  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // S-box applied to all sixteen nibbles.
  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] o;
    for (int n = 0; n < BLK_W / 4; n++) begin
      o[4*n +: 4] = sbox4(s[4*n +: 4]);
    end
    return o;
  endfunction

  // Bit i moves to bit i/4 + 16*(i%4).
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] o;
    for (int i = 0; i < BLK_W; i++) begin
      o[(i >> 2) + ((i & 3) << 4)] = s[i];
    end
    return o;
  endfunction

  // The round key is the top 64 bits of the key register.
  function automatic logic [BLK_W-1:0] top64(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: BLK_W];
  endfunction

  // Key update: rotate left by 61, S-box on the top nibble, round counter into bits 19..15.
  function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k,
                                                input logic [RC_W-1:0]  rc);
    logic [KEY_W-1:0] n;
    n = {k[18:0], k[KEY_W-1:19]};
    n[KEY_W-1 -: 4] = sbox4(n[KEY_W-1 -: 4]);
    n[19:15] = n[19:15] ^ rc;
    return n;
  endfunction

endpackage

>>> rtl/core/pr80_stream_if.sv
// Valid/ready stream interfaces for plaintext items and ciphertext items.
// Depends on pr80_pkg for the block width.
interface pr80_pt_if import pr80_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink   (input valid, input plaintext, output ready);
endinterface

interface pr80_ct_if import pr80_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink   (input valid, input ciphertext, output ready);
endinterface

>>> rtl/core/pr80_round_cell.sv
// One PRESENT round cell: add round key, S-box layer, permutation, key update.
// Depends on pr80_pkg for the stage record and the round functions.
module pr80_round_cell import pr80_pkg::*; #(
  parameter int ROUND_IDX = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  pr80_stage_t stage_in,
  output pr80_stage_t stage_out
);

  localparam logic [RC_W-1:0] RC = RC_W'(ROUND_IDX);

  logic             valid_r;
  logic [BLK_W-1:0] state_r, state_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  // Round datapath on the item entering this cell.
  always_comb begin
    state_nxt = perm_layer(sub_layer(stage_in.state ^ top64(stage_in.key)));
    key_nxt   = next_key(stage_in.key, RC);
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_in.valid;
    end
  end

  // Block and key registers carry no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  assign stage_out = '{valid: valid_r, state: state_r, key: key_r};

endmodule

>>> rtl/core/present80_block_encrypt_core.sv
// Top level of the PRESENT-80 encryption core: key registers, the chain of
// round cells and the output register. Depends on pr80_pkg, pr80_stream_if
// and pr80_round_cell.
//
//   channel   dir  handshake          payload
//   in_blk    in   valid/ready        plaintext  [63:0]
//   out_blk   out  valid/ready        ciphertext [63:0]
//   cfg_*     in   cfg_we (no wait)   cfg_index, cfg_wdata [63:0]
//
// One item enters per cycle while no result waits unclaimed on out_blk; each item passes
// one round cell per round, then the output register holding the final key addition.
// The whole chain advances together; when a result waits unclaimed on out_blk,
// the chain and in_blk.ready hold until it is taken.
// Synchronous reset empties the chain and clears the key to zero.
module present80_block_encrypt_core import pr80_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pr80_pt_if.sink              in_blk,
  pr80_ct_if.source            out_blk,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLK_W-1:0]     cfg_wdata
);

  logic [BLK_W-1:0]      key_low_r;
  logic [KEY_HIGH_W-1:0] key_high_r;
  logic                  en;
  pr80_stage_t           chain [0:ROUNDS];
  logic                  out_valid_r;
  logic [BLK_W-1:0]      out_data_r;

  // Configuration writes; the user must change the key only while the core is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        CFG_KEY_HIGH: key_high_r <= cfg_wdata[KEY_HIGH_W-1:0];
        default:      ;
      endcase
    end
  end

  // The chain moves unless a finished item is stuck at the output.
  assign en           = !out_valid_r || out_blk.ready;
  assign in_blk.ready = en;

  assign chain[0] = '{valid: in_blk.valid, state: in_blk.plaintext,
                      key: {key_high_r, key_low_r}};

  // One cell per round; the key schedule rides along with each item.
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    pr80_round_cell #(
      .ROUND_IDX(g + 1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .stage_in (chain[g]),
      .stage_out(chain[g+1])
    );
  end

  // Output register with the final key addition.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= chain[ROUNDS].state ^ top64(chain[ROUNDS].key);
    end
  end

  assign out_blk.valid      = out_valid_r;
  assign out_blk.ciphertext = out_data_r;

endmodule

>>> rtl/core/pr80_checker.sv
// Port-level checks for the PRESENT-80 encryption core and the bind that
// attaches them. Depends on pr80_pkg and present80_block_encrypt_core.
module pr80_checker import pr80_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [BLK_W-1:0] ciphertext
);

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An unclaimed result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The core takes a new item whenever the output is free or being taken.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // A stalled result blocks intake and keeps its value.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready ##1 $stable(ciphertext))
    else $error("intake or result changed during a stall");

endmodule

bind present80_block_encrypt_core pr80_checker u_pr80_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_blk.ready),
  .out_valid (out_blk.valid),
  .out_ready (out_blk.ready),
  .ciphertext(out_blk.ciphertext)
);

>>> bench/tb.sv
// Self-checking bench for present80_block_encrypt_core: directed known-answer blocks, then
// randomized blocks under several keys and handshake pacing modes, checked by a local cipher model.
// Depends on pr80_pkg, pr80_stream_if and the core RTL.
module tb;
  import pr80_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SEGMENTS        = 8;
  localparam int BLOCKS_PER_SEG  = 100;
  // S-box entry n sits in nibble n.
  localparam logic [63:0] SBOX_NIBBLES = 64'h2174_8FE3_DA09_B65C;

  typedef struct {
    bit          rekey;
    logic [63:0] key_lo;
    logic [63:0] key_hi_word;
    logic [63:0] pt;
    bit          known;
    logic [63:0] ct;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLK_W-1:0]     cfg_wdata;

  pr80_pt_if pt_if ();
  pr80_ct_if ct_if ();

  logic [KEY_W-1:0] cipher_key = '0;
  logic [63:0]      ct_expected[$];
  int               sender_idle_pct = 0;
  int               sink_stall_pct = 0;
  int               n_blocks = 0;
  int               n_checked = 0;
  int               n_keys = 1;
  int               n_errors = 0;
  int               quiet_cycles = 0;

  // Directed blocks; the first four ciphertexts are the published known-answer vectors.
  stim_row_t stim_rows [18] = '{
    '{1'b0, 64'h0, 64'h0, 64'h0000000000000000, 1'b1, 64'h5579C1387B228445},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'hA112FFC72F68417B},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFF, 64'h0000000000000000, 1'b1, 64'hE72C46C0F5945049},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h3333DCD3213210D2},
    // Bits above the 16-bit high key word must be ignored, so the key is zero again.
    '{1'b1, 64'h0, 64'hFFFFFFFFFFFF0000, 64'h0000000000000000, 1'b1, 64'h5579C1387B228445},
    '{1'b1, 64'h0, 64'hFFFF, 64'h0123456789ABCDEF, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h0000000000000000, 1'b0, 64'h0},
    '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h0, 64'hFEDCBA9876543210, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
    '{1'b1, 64'h0123456789ABCDEF, 64'h5A5A000000001234, 64'h5555555555555555, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h0000000000000001, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h8000000000000000, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h00000000FFFFFFFF, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'hFFFFFFFF00000000, 1'b0, 64'h0},
    '{1'b1, 64'h0000000000000001, 64'h8000, 64'h0000000000000000, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'h0F0F0F0F0F0F0F0F, 1'b0, 64'h0},
    '{1'b0, 64'h0, 64'h0, 64'hF0F0F0F0F0F0F0F0, 1'b0, 64'h0}
  };

  present80_block_encrypt_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_blk    (pt_if),
    .out_blk   (ct_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Full PRESENT-80 encryption of one block with a fresh key schedule.
  function automatic logic [63:0] present80_encrypt(input logic [63:0] pt,
                                                    input logic [79:0] key);
    logic [63:0] st;
    logic [63:0] sub;
    logic [79:0] rk;
    st = pt;
    rk = key;
    for (int r = 1; r <= ROUNDS_DEF; r++) begin
      st = st ^ rk[79:16];
      for (int n = 0; n < 16; n++) begin
        sub[4*n +: 4] = SBOX_NIBBLES[4*st[4*n +: 4] +: 4];
      end
      for (int i = 0; i < 64; i++) begin
        st[i/4 + 16*(i%4)] = sub[i];
      end
      rk = {rk[18:0], rk[79:19]};
      rk[79:76] = SBOX_NIBBLES[4*rk[79:76] +: 4];
      rk[19:15] = rk[19:15] ^ r[4:0];
    end
    return st ^ rk[79:16];
  endfunction

  // Hold off the sender until every outstanding ciphertext has come back.
  task automatic drain_pipeline();
    pt_if.valid <= 1'b0;
    while (ct_expected.size() != 0) @(posedge clk);
  endtask

  // Write both key registers while the core is empty.
  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi_word);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_KEY_HIGH;
    cfg_wdata <= hi_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cipher_key = {hi_word[15:0], lo};
    n_keys++;
  endtask

  // Offer one plaintext item after a random gap and queue its ciphertext once accepted.
  task automatic push_block(input logic [63:0] pt, input bit known, input logic [63:0] ct);
    while ($urandom_range(99) < sender_idle_pct) begin
      pt_if.valid <= 1'b0;
      pt_if.plaintext <= {$urandom, $urandom};
      @(posedge clk);
    end
    pt_if.valid     <= 1'b1;
    pt_if.plaintext <= pt;
    do @(posedge clk); while (!pt_if.ready);
    ct_expected.push_back(known ? ct : present80_encrypt(pt, cipher_key));
    n_blocks++;
  endtask

  // Receiver: random back-pressure and in-order ciphertext check.
  always @(posedge clk) begin
    ct_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    if (rst_n && ct_if.valid && ct_if.ready) begin
      if (ct_expected.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, ct_if.ciphertext);
        n_errors++;
      end else begin
        if (ct_if.ciphertext !== ct_expected[0]) begin
          $display("%0t: ciphertext mismatch: expected %h, actual %h",
                   $time, ct_expected[0], ct_if.ciphertext);
          n_errors++;
        end
        void'(ct_expected.pop_front());
        n_checked++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (pt_if.valid && pt_if.ready) || (ct_if.valid && ct_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d ciphertexts outstanding",
               $time, ct_expected.size());
      $display("present80_block_encrypt_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [63:0] lo;
    logic [63:0] hi_word;
    logic [63:0] pt;
    int          pick;
    pt_if.valid     = 1'b0;
    pt_if.plaintext = '0;
    ct_if.ready     = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_KEY_LOW;
    cfg_wdata       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset key of zero.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].rekey) begin
        load_key(stim_rows[i].key_lo, stim_rows[i].key_hi_word);
      end
      push_block(stim_rows[i].pt, stim_rows[i].known, stim_rows[i].ct);
    end

    // Random part: one key per segment, pacing mode cycles through the four settings.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 77; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 77; end
        default: begin sender_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      lo      = {$urandom, $urandom};
      hi_word = {$urandom, $urandom};
      if (seg == 0) begin
        lo      = '1;
        hi_word = hi_word | 64'hFFFF;
      end else if (seg == 1) begin
        lo      = '0;
        hi_word = hi_word & ~64'hFFFF;
      end
      load_key(lo, hi_word);
      for (int k = 0; k < BLOCKS_PER_SEG; k++) begin
        if (k == BLOCKS_PER_SEG / 2) begin
          drain_pipeline();
        end
        pick = $urandom_range(9);
        case (pick)
          0: pt = $urandom_range(1) ? '1 : '0;
          1: pt = 64'd1 << $urandom_range(63);
          2: pt = ~(64'd1 << $urandom_range(63));
          default: pt = {$urandom, $urandom};
        endcase
        push_block(pt, 1'b0, '0);
      end
    end

    // Let the pipeline empty, then watch a little longer for stray results.
    drain_pipeline();
    repeat (ROUNDS_DEF + 8) @(posedge clk);

    $display("Encrypted %0d blocks under %0d key settings; %0d ciphertexts compared.",
             n_blocks, n_keys, n_checked);
    $display("Pacing covered free flow, sparse sender, stalling receiver and mixed idling.");
    if (n_errors == 0) begin
      $display("present80_block_encrypt_core regression: pass");
    end else begin
      $display("present80_block_encrypt_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pr80_pkg.sv
rtl/core/pr80_stream_if.sv
rtl/core/pr80_round_cell.sv
rtl/core/present80_block_encrypt_core.sv
rtl/core/pr80_checker.sv
bench/tb.sv
